/* design/jsu_pkg.sv */
package jsu_pkg;

  // Parser phase of the front end.
  typedef enum logic [1:0] {
    PH_IDLE,
    PH_STR,
    PH_ESC,
    PH_HEX
  } phase_e;

  // Kind of one result.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_ERR   = 2'd2
  } kind_e;

  // Error codes reported with an error result.
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_NO_QUOTE = 3'd1,
    ERR_BAD_ESC  = 3'd2,
    ERR_BAD_HEX  = 3'd3,
    ERR_CTRL     = 3'd4,
    ERR_UNTERM   = 3'd5,
    ERR_TRUNC    = 3'd6
  } err_e;

  // One queued command: all results caused by one input byte.
  // last_idx is the number of results minus one.
  typedef struct packed {
    kind_e            kind;
    logic [2:0][7:0]  bytes;
    err_e             err;
    logic [1:0]       last_idx;
  } cmd_t;

  // Default depth of the command queue (a power of two, at least 2).
  localparam int unsigned FIFO_DEPTH = 2;

endpackage

/* design/jsu_in_if.sv */
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink (input valid, input in_byte, input end_of_text, output ready);
endinterface

/* design/jsu_out_if.sv */
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [2:0] error_code;
  logic       last;

  modport source (output valid, output kind, output out_byte, output error_code,
                  output last, input ready);
  modport sink (input valid, input kind, input out_byte, input error_code,
                input last, output ready);
endinterface

/* design/jsu_front.sv */
module jsu_front import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  jsu_in_if.sink     in_i,
  input  logic       full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChLowB   = 8'h62;
  localparam logic [7:0] ChLowF   = 8'h66;
  localparam logic [7:0] ChLowN   = 8'h6E;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] CtrlLim  = 8'h20;

  phase_e      phase_q, phase_d;
  logic [11:0] code_q, code_d;
  logic [1:0]  hex_cnt_q, hex_cnt_d;

  logic        acc;
  logic [7:0]  c;
  logic        eot;
  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] code_full;
  logic        emit;
  cmd_t        cmd;

  // Build an error command.
  function automatic cmd_t err_cmd(input err_e e);
    cmd_t r;
    r          = '0;
    r.kind     = KIND_ERR;
    r.err      = e;
    return r;
  endfunction

  // Build a single data byte command.
  function automatic cmd_t data_cmd(input logic [7:0] b);
    cmd_t r;
    r          = '0;
    r.kind     = KIND_DATA;
    r.bytes[0] = b;
    return r;
  endfunction

  assign in_i.ready = !full_i;
  assign acc        = in_i.valid && !full_i;
  assign c          = in_i.in_byte;
  assign eot        = in_i.end_of_text;

  // Hex digit decode, either case.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      hex_val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      hex_val = 4'(c - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign code_full = {code_q, hex_val};

  // Next state of the parser.
  always_comb begin
    phase_d   = phase_q;
    code_d    = code_q;
    hex_cnt_d = hex_cnt_q;
    if (acc) begin
      case (phase_q)
        PH_STR: begin
          if (eot || c == ChQuote || c < CtrlLim) begin
            phase_d = PH_IDLE;
          end else if (c == ChBslash) begin
            phase_d = PH_ESC;
          end
        end
        PH_ESC: begin
          if (eot) begin
            phase_d = PH_IDLE;
          end else begin
            case (c)
              ChQuote, ChBslash, ChSlash, ChLowB, ChLowF, ChLowN, ChLowR, ChLowT: begin
                phase_d = PH_STR;
              end
              ChLowU: begin
                phase_d   = PH_HEX;
                code_d    = '0;
                hex_cnt_d = '0;
              end
              default: begin
                phase_d = PH_IDLE;
              end
            endcase
          end
        end
        PH_HEX: begin
          if (eot || !hex_ok) begin
            phase_d   = PH_IDLE;
            code_d    = '0;
            hex_cnt_d = '0;
          end else if (hex_cnt_q != 2'd3) begin
            code_d    = code_full[11:0];
            hex_cnt_d = hex_cnt_q + 2'd1;
          end else begin
            phase_d   = PH_STR;
            code_d    = '0;
            hex_cnt_d = '0;
          end
        end
        default: begin
          if (!eot && c == ChQuote) begin
            phase_d   = PH_STR;
            code_d    = '0;
            hex_cnt_d = '0;
          end
        end
      endcase
    end
  end

  // Results caused by the current byte.
  always_comb begin
    emit = 1'b0;
    cmd  = '0;
    case (phase_q)
      PH_STR: begin
        emit = 1'b1;
        if (eot) begin
          cmd = err_cmd(ERR_UNTERM);
        end else if (c == ChQuote) begin
          cmd.kind = KIND_CLOSE;
        end else if (c == ChBslash) begin
          emit = 1'b0;
        end else if (c < CtrlLim) begin
          cmd = err_cmd(ERR_CTRL);
        end else begin
          cmd = data_cmd(c);
        end
      end
      PH_ESC: begin
        emit = 1'b1;
        if (eot) begin
          cmd = err_cmd(ERR_UNTERM);
        end else begin
          case (c)
            ChQuote, ChBslash, ChSlash: cmd = data_cmd(c);
            ChLowB: cmd = data_cmd(8'h08);
            ChLowF: cmd = data_cmd(8'h0C);
            ChLowN: cmd = data_cmd(8'h0A);
            ChLowR: cmd = data_cmd(8'h0D);
            ChLowT: cmd = data_cmd(8'h09);
            ChLowU: emit = 1'b0;
            default: cmd = err_cmd(ERR_BAD_ESC);
          endcase
        end
      end
      PH_HEX: begin
        emit = 1'b1;
        if (eot) begin
          cmd = err_cmd(ERR_TRUNC);
        end else if (!hex_ok) begin
          cmd = err_cmd(ERR_BAD_HEX);
        end else if (hex_cnt_q != 2'd3) begin
          emit = 1'b0;
        end else if (code_full[15:7] == '0) begin
          cmd = data_cmd(code_full[7:0]);
        end else if (code_full[15:11] == '0) begin
          cmd.kind     = KIND_DATA;
          cmd.bytes[0] = {3'b110, code_full[10:6]};
          cmd.bytes[1] = {2'b10, code_full[5:0]};
          cmd.last_idx = 2'd1;
        end else begin
          cmd.kind     = KIND_DATA;
          cmd.bytes[0] = {4'b1110, code_full[15:12]};
          cmd.bytes[1] = {2'b10, code_full[11:6]};
          cmd.bytes[2] = {2'b10, code_full[5:0]};
          cmd.last_idx = 2'd2;
        end
      end
      default: begin
        if (eot || c != ChQuote) begin
          emit = 1'b1;
          cmd  = err_cmd(ERR_NO_QUOTE);
        end
      end
    endcase
  end

  assign push_o = acc && emit;
  assign cmd_o  = cmd;

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      code_q    <= '0;
      hex_cnt_q <= '0;
    end else begin
      phase_q   <= phase_d;
      code_q    <= code_d;
      hex_cnt_q <= hex_cnt_d;
    end
  end

endmodule

/* design/jsu_fifo.sv */
module jsu_fifo import jsu_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t data_o
);

  localparam int unsigned AddrW = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  cmd_t             mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Storage; the front only pushes when there is room.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + AddrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + AddrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* design/jsu_back.sv */
module jsu_back import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  cmd_t       cmd_i,
  output logic       pop_o,
  jsu_out_if.source  out_o
);

  cmd_t       cur_q;
  logic       busy_q;
  logic [1:0] idx_q;
  logic       is_last;
  logic       fin;
  logic       load;

  assign is_last = (idx_q == cur_q.last_idx);
  assign fin     = busy_q && out_o.ready && is_last;
  assign load    = valid_i && (!busy_q || fin);
  assign pop_o   = load;

  // Present the current result of the held command.
  always_comb begin
    out_o.valid      = busy_q;
    out_o.kind       = cur_q.kind;
    out_o.error_code = cur_q.err;
    out_o.last       = is_last;
    case (idx_q)
      2'd1:    out_o.out_byte = cur_q.bytes[1];
      2'd2:    out_o.out_byte = cur_q.bytes[2];
      default: out_o.out_byte = cur_q.bytes[0];
    endcase
  end

  // Command register; payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= cmd_i;
    end
  end

  // Result sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (fin) begin
        busy_q <= 1'b0;
        idx_q  <= '0;
      end else if (busy_q && out_o.ready) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

endmodule

/* design/json_string_unescape.sv */
// JSON string unescaper.
// The input channel carries one raw text byte per request (in_byte), or an
// end-of-text marker (end_of_text). The text of a string starts with its
// opening quote. The output channel carries one result per request: a data
// byte, a "string closed" mark or an error with its code, and last marks the
// final result caused by one input byte.
// Throughput is one input byte per cycle while each byte causes at most one
// result and the receiver is ready. A \u escape giving two or three UTF-8 bytes
// holds the output stage until all are taken; the command queue absorbs this
// and intake stalls only once the queue is full. The results of a byte are
// queued when it is accepted, then loaded into the output stage register.
// Reset clears the parser to idle (awaiting an opening quote) and empties the
// queue and output stage. When the receiver stalls, the current result holds
// steady, the queue fills, and then the input ready goes low.
module json_string_unescape import jsu_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  logic push;
  logic full;
  logic pop;
  logic q_valid;
  cmd_t push_cmd;
  cmd_t pop_cmd;

  // Parser and classifier.
  jsu_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  // Command queue between parser and output sequencer.
  jsu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (pop_cmd)
  );

  // Output sequencer.
  jsu_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_valid),
    .cmd_i   (pop_cmd),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

/* test/tb_json_string_unescape.sv */
module tb_json_string_unescape import jsu_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam int unsigned TEXT_ITEMS = 470;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 10;

  typedef struct {
    logic [7:0] data;
    logic       eot;
  } text_item_t;

  typedef struct {
    kind_e      kind;
    logic [7:0] data;
    err_e       err;
    logic       last;
  } result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  text_if ();
  jsu_out_if res_if ();

  json_string_unescape dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (text_if),
    .out_o  (res_if)
  );

  always #2 clk_i = ~clk_i;

  text_item_t  text_q [$];
  result_t     decoded_q [$];
  text_item_t  next_item;
  result_t     want;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  int unsigned n_items = 0;

  // Mirror of the unescaper state.
  phase_e      ph;
  logic [15:0] code_acc;
  logic [1:0]  hex_cnt;

  // Random back-pressure on both sides, with one long calm stretch.
  function automatic bit hold_off();
    if (cycle_cnt >= 300 && cycle_cnt < 700) return 1'b0;
    return $urandom_range(0, 99) < 20;
  endfunction

  // Bit 4 flags a hex digit; bits 3:0 hold its value.
  function automatic logic [4:0] hex_val(logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
    if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
    if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
    return 5'd0;
  endfunction

  function automatic result_t mk_result(kind_e k, logic [7:0] d, err_e e);
    result_t r;
    r.kind = k;
    r.data = d;
    r.err  = e;
    r.last = 1'b0;
    return r;
  endfunction

  // Work out the results of one text byte and update the mirrored state.
  task automatic unescape_step(input logic [7:0] c, input logic eot);
    result_t     res [$];
    err_e        err;
    logic [4:0]  hv;
    logic [15:0] code;
    err = ERR_NONE;
    case (ph)
      PH_STR: begin
        if (eot) err = ERR_UNTERM;
        else if (c == CH_QUOTE) begin
          ph = PH_IDLE;
          res.insert(res.size(), mk_result(KIND_CLOSE, 8'd0, ERR_NONE));
        end else if (c == CH_BSLASH) ph = PH_ESC;
        else if (c < 8'h20) err = ERR_CTRL;
        else res.insert(res.size(), mk_result(KIND_DATA, c, ERR_NONE));
      end
      PH_ESC: begin
        if (eot) err = ERR_UNTERM;
        else begin
          ph = PH_STR;
          case (c)
            CH_QUOTE, CH_BSLASH, "/": res.insert(res.size(), mk_result(KIND_DATA, c, ERR_NONE));
            "b": res.insert(res.size(), mk_result(KIND_DATA, 8'h08, ERR_NONE));
            "f": res.insert(res.size(), mk_result(KIND_DATA, 8'h0C, ERR_NONE));
            "n": res.insert(res.size(), mk_result(KIND_DATA, 8'h0A, ERR_NONE));
            "r": res.insert(res.size(), mk_result(KIND_DATA, 8'h0D, ERR_NONE));
            "t": res.insert(res.size(), mk_result(KIND_DATA, 8'h09, ERR_NONE));
            "u": begin
              ph = PH_HEX;
              code_acc = '0;
              hex_cnt = '0;
            end
            default: err = ERR_BAD_ESC;
          endcase
        end
      end
      PH_HEX: begin
        hv = hex_val(c);
        if (eot) err = ERR_TRUNC;
        else if (!hv[4]) err = ERR_BAD_HEX;
        else begin
          code = {code_acc[11:0], hv[3:0]};
          if (hex_cnt != 2'd3) begin
            code_acc = code;
            hex_cnt = hex_cnt + 2'd1;
          end else begin
            ph = PH_STR;
            code_acc = '0;
            hex_cnt = '0;
            // UTF-8 encoding of one code unit; surrogates are left uncombined.
            if (code <= 16'h007F) begin
              res.insert(res.size(), mk_result(KIND_DATA, code[7:0], ERR_NONE));
            end else if (code <= 16'h07FF) begin
              res.insert(res.size(), mk_result(KIND_DATA, {3'b110, code[10:6]}, ERR_NONE));
              res.insert(res.size(), mk_result(KIND_DATA, {2'b10, code[5:0]}, ERR_NONE));
            end else begin
              res.insert(res.size(), mk_result(KIND_DATA, {4'b1110, code[15:12]}, ERR_NONE));
              res.insert(res.size(), mk_result(KIND_DATA, {2'b10, code[11:6]}, ERR_NONE));
              res.insert(res.size(), mk_result(KIND_DATA, {2'b10, code[5:0]}, ERR_NONE));
            end
          end
        end
      end
      default: begin
        if (eot || c != CH_QUOTE) err = ERR_NO_QUOTE;
        else begin
          ph = PH_STR;
          code_acc = '0;
          hex_cnt = '0;
        end
      end
    endcase
    // Any error drops back to idle with a single error result.
    if (err != ERR_NONE) begin
      ph = PH_IDLE;
      code_acc = '0;
      hex_cnt = '0;
      res = {mk_result(KIND_ERR, 8'd0, err)};
    end
    if (res.size() != 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) decoded_q.insert(decoded_q.size(), res[i]);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS) $display("[%0t] %s", $realtime, msg);
  endtask

  // Stimulus helpers.
  task automatic add_text(input logic [7:0] c, input logic eot);
    text_item_t t;
    t.data = c;
    t.eot  = eot;
    text_q.insert(text_q.size(), t);
    n_items++;
  endtask

  task automatic add_chars(input string s);
    for (int i = 0; i < s.len(); i++) add_text(s[i], 1'b0);
  endtask

  function automatic logic [7:0] hex_digit(logic [3:0] nib);
    if (nib < 4'd10) return "0" + 8'(nib);
    return ($urandom_range(0, 1) ? "A" : "a") + 8'(nib) - 8'd10;
  endfunction

  // One well-formed piece of string content.
  task automatic add_piece();
    string       esc_letters;
    int unsigned roll;
    logic [7:0]  c;
    logic [15:0] code;
    esc_letters = "\"\\/bfnrt";
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      do c = 8'($urandom_range(8'h20, 8'hFF)); while (c == CH_QUOTE || c == CH_BSLASH);
      add_text(c, 1'b0);
    end else if (roll < 75) begin
      add_text(CH_BSLASH, 1'b0);
      add_text(esc_letters[$urandom_range(0, 7)], 1'b0);
    end else begin
      case ($urandom_range(0, 2))
        0: code = 16'($urandom_range(16'h0000, 16'h007F));
        1: code = 16'($urandom_range(16'h0080, 16'h07FF));
        default: code = 16'($urandom_range(16'h0800, 16'hFFFF));
      endcase
      add_chars("\\u");
      for (int i = 3; i >= 0; i--) add_text(hex_digit(code[4*i +: 4]), 1'b0);
    end
  endtask

  // One way of breaking a string partway through.
  task automatic add_fault();
    logic [7:0] c;
    logic [4:0] hv;
    int unsigned ndig;
    case ($urandom_range(0, 5))
      0: add_text(8'($urandom_range(8'h00, 8'h1F)), 1'b0);
      1: begin
        add_text(CH_BSLASH, 1'b0);
        do c = 8'($urandom_range(0, 255));
        while (c inside {CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", "u"});
        add_text(c, 1'b0);
      end
      2, 3: begin
        add_chars("\\u");
        ndig = $urandom_range(0, 3);
        for (int i = 0; i < ndig; i++) add_text(hex_digit(4'($urandom_range(0, 15))), 1'b0);
        do begin
          c  = 8'($urandom_range(0, 255));
          hv = hex_val(c);
        end while (hv[4]);
        add_text(c, 1'($urandom_range(0, 1)));
      end
      4: add_text(8'($urandom_range(0, 255)), 1'b1);
      default: begin
        add_text(CH_BSLASH, 1'b0);
        add_text(8'($urandom_range(0, 255)), 1'b1);
      end
    endcase
  endtask

  // A string literal with random content, optionally broken at a random point.
  task automatic add_string(input bit broken);
    int npieces;
    int brk_at;
    npieces = $urandom_range(0, 8);
    brk_at = broken ? int'($urandom_range(0, npieces)) : -1;
    add_text(CH_QUOTE, 1'b0);
    for (int i = 0; i <= npieces; i++) begin
      if (i == brk_at) begin
        add_fault();
        return;
      end
      if (i < npieces) add_piece();
      else add_text(CH_QUOTE, 1'b0);
    end
  endtask

  // Request driver: presents queued text bytes, holding each until accepted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_cnt <= cycle_cnt + 1;
      if (!text_if.valid || text_if.ready) begin
        if (text_q.size() != 0 && !hold_off()) begin
          next_item = text_q.pop_front();
          text_if.valid       <= 1'b1;
          text_if.in_byte     <= next_item.data;
          text_if.end_of_text <= next_item.eot;
        end else begin
          text_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on accepted input, checks accepted results, drives ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (text_if.valid && text_if.ready) unescape_step(text_if.in_byte, text_if.end_of_text);
      if (res_if.valid && res_if.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind=%0d byte=%02h err=%0d last=%0b",
                                    res_if.kind, res_if.out_byte, res_if.error_code,
                                    res_if.last));
        end else begin
          want = decoded_q.pop_front();
          if (res_if.kind !== want.kind || res_if.out_byte !== want.data ||
              res_if.error_code !== want.err || res_if.last !== want.last) begin
            report_mismatch({$sformatf("expected kind=%0d byte=%02h err=%0d last=%0b, ",
                                       want.kind, want.data, want.err, want.last),
                             $sformatf("got kind=%0d byte=%02h err=%0d last=%0b",
                                       res_if.kind, res_if.out_byte, res_if.error_code,
                                       res_if.last)});
          end
        end
      end
      res_if.ready <= !hold_off();
    end
  end

  initial begin
    rst_ni = 1'b0;
    text_if.valid = 1'b0;
    text_if.in_byte = 8'd0;
    text_if.end_of_text = 1'b0;
    res_if.ready = 1'b0;
    ph = PH_IDLE;
    code_acc = '0;
    hex_cnt = '0;

    // Directed: idle errors, byte extremes, a three-byte escape, each error path.
    add_chars("x");
    add_text(8'h00, 1'b1);
    add_chars("\"");
    add_text(8'hFF, 1'b0);
    add_chars(" \\uFfA9\\q");
    add_chars("\"");
    add_text(8'h1F, 1'b0);
    add_chars("\"\\");
    add_text(8'h00, 1'b1);
    add_chars("\"");
    add_text(CH_QUOTE, 1'b1);
    add_chars("\"\\u0\"");
    add_chars("\"\\u");
    add_text(8'hFF, 1'b1);
    add_chars("\"\"");

    // Random: mostly well-formed strings, some broken ones and stray bytes.
    while (n_items < TEXT_ITEMS) begin
      case ($urandom_range(0, 99)) inside
        [0:79]:  add_string(1'b0);
        [80:91]: add_string(1'b1);
        default: add_text(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
      endcase
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all requests sent and every expected result seen.
    @(negedge clk_i);
    while (text_q.size() != 0 || text_if.valid || decoded_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog against a stalled pipeline.
  initial begin
    #400_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

/* sim.f */
design/jsu_pkg.sv
design/jsu_in_if.sv
design/jsu_out_if.sv
design/jsu_front.sv
design/jsu_fifo.sv
design/jsu_back.sv
design/json_string_unescape.sv
test/tb_json_string_unescape.sv
